/* rtl/msch_pkg.sv */
// ----------------------------------------------------------------------------
// msch_pkg
// Shared types, codes and sizes for the multi-policy job scheduler.
// ----------------------------------------------------------------------------
package msch_pkg;

	localparam int DEPTH = 16;
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	localparam int TIME_W = 32;
	localparam int JOB_W  = 16;
	localparam int LEN_W  = 24;
	localparam int PRI_W  = 8;
	localparam int POL_W  = 3;
	localparam int MODE_W = 2;
	localparam int STAT_W = 2;

	// scheduling policies
	localparam logic [POL_W-1:0] POL_FCFS = 3'd0;
	localparam logic [POL_W-1:0] POL_SJF  = 3'd1;
	localparam logic [POL_W-1:0] POL_PSJF = 3'd2;
	localparam logic [POL_W-1:0] POL_PRI  = 3'd3;
	localparam logic [POL_W-1:0] POL_PPRI = 3'd4;
	localparam logic [POL_W-1:0] POL_RR   = 3'd5;

	// event kinds
	localparam logic [MODE_W-1:0] MODE_ARRIVE = 2'd0;
	localparam logic [MODE_W-1:0] MODE_FINISH = 2'd1;
	localparam logic [MODE_W-1:0] MODE_EXPIRE = 2'd2;

	// result status codes
	localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL    = 2'd1;
	localparam logic [STAT_W-1:0] ST_EMPTY   = 2'd2;
	localparam logic [STAT_W-1:0] ST_IGNORED = 2'd3;

	typedef enum logic [3:0] {
		CMD_NOP,
		CMD_LOAD,
		CMD_DROP,
		CMD_SCAN0,
		CMD_SCAN1,
		CMD_PSJF,
		CMD_APPEND,
		CMD_STEP,
		CMD_INSERT,
		CMD_FINISH,
		CMD_EMPTY,
		CMD_IGNORE,
		CMD_ROTATE,
		CMD_RESULT
	} cmd_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_SCAN,
		S_INSERT,
		S_RESULT,
		S_OUT
	} state_t;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [POL_W-1:0]  pol;
		logic              empty;
		logic              full;
		logic              scan_done;
	} dp_status_t;

endpackage

/* rtl/msch_ctrl.sv */
// ----------------------------------------------------------------------------
// msch_ctrl
// Sequencer: decodes each event and steps the datapath through the scan,
// the queue update and the result hand-off.
// ----------------------------------------------------------------------------
module msch_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	output logic                out_valid,
	input  logic                out_stall,
	input  msch_pkg::dp_status_t dp_st,
	output msch_pkg::cmd_t      cmd
);
	import msch_pkg::*;

	state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d   = state_q;
		cmd       = CMD_NOP;
		in_stall  = 1'b1;
		out_valid = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd     = CMD_LOAD;
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				state_d = S_RESULT;
				case (dp_st.mode)
					MODE_ARRIVE: begin
						if (dp_st.full) begin
							cmd = CMD_DROP;
						end else if (dp_st.empty) begin
							cmd     = CMD_APPEND;
							state_d = S_INSERT;
						end else begin
							case (dp_st.pol)
								POL_SJF, POL_PRI: begin
									cmd     = CMD_SCAN1;
									state_d = S_SCAN;
								end
								POL_PSJF: begin
									cmd     = CMD_PSJF;
									state_d = S_SCAN;
								end
								POL_PPRI: begin
									cmd     = CMD_SCAN0;
									state_d = S_SCAN;
								end
								default: begin
									cmd     = CMD_APPEND;
									state_d = S_INSERT;
								end
							endcase
						end
					end
					MODE_FINISH: begin
						cmd = dp_st.empty ? CMD_EMPTY : CMD_FINISH;
					end
					MODE_EXPIRE: begin
						if (dp_st.pol != POL_RR) begin
							cmd = CMD_IGNORE;
						end else if (dp_st.empty) begin
							cmd = CMD_EMPTY;
						end else begin
							cmd = CMD_ROTATE;
						end
					end
					default: begin
						cmd = CMD_NOP;
					end
				endcase
			end
			S_SCAN: begin
				// advance until the first strictly greater key or the tail
				if (dp_st.scan_done) begin
					state_d = S_INSERT;
				end else begin
					cmd = CMD_STEP;
				end
			end
			S_INSERT: begin
				cmd     = CMD_INSERT;
				state_d = S_RESULT;
			end
			S_RESULT: begin
				cmd     = CMD_RESULT;
				state_d = S_OUT;
			end
			S_OUT: begin
				out_valid = 1'b1;
				if (!out_stall) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

/* rtl/msch_dp.sv */
// ----------------------------------------------------------------------------
// msch_dp
// Datapath: job queue registers, insertion scan pointer, time arithmetic
// and the result register.
// ----------------------------------------------------------------------------
module msch_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [msch_pkg::POL_W-1:0]    cfg_wr_data,
	input  msch_pkg::cmd_t                cmd,
	output msch_pkg::dp_status_t          dp_st,
	input  logic [msch_pkg::MODE_W-1:0]   mode,
	input  logic [msch_pkg::TIME_W-1:0]   event_time,
	input  logic [msch_pkg::JOB_W-1:0]    job_id,
	input  logic [msch_pkg::LEN_W-1:0]    run_length,
	input  logic [msch_pkg::PRI_W-1:0]    job_priority,
	output logic                          run_valid,
	output logic [msch_pkg::JOB_W-1:0]    run_job,
	output logic [msch_pkg::STAT_W-1:0]   status,
	output logic                          stats_valid,
	output logic [msch_pkg::TIME_W-1:0]   turnaround,
	output logic [msch_pkg::TIME_W-1:0]   waiting,
	output logic [msch_pkg::TIME_W-1:0]   response
);
	import msch_pkg::*;

	// queue entries, head at index 0
	logic [JOB_W-1:0]  job_q  [DEPTH];
	logic [TIME_W-1:0] arr_q  [DEPTH];
	logic [LEN_W-1:0]  len_q  [DEPTH];
	logic [LEN_W-1:0]  rem_q  [DEPTH];
	logic [PRI_W-1:0]  prio_q [DEPTH];
	logic [TIME_W-1:0] fr_q   [DEPTH];
	logic [DEPTH-1:0]  hr_q;

	logic [CNT_W-1:0]  occ_q;
	logic [TIME_W-1:0] hrs_q;
	logic [POL_W-1:0]  pol_q;
	logic [CNT_W-1:0]  pos_q;

	// latched event
	logic [MODE_W-1:0] ev_mode_q;
	logic [TIME_W-1:0] ev_time_q;
	logic [JOB_W-1:0]  ev_job_q;
	logic [LEN_W-1:0]  ev_len_q;
	logic [PRI_W-1:0]  ev_pri_q;

	// finish figures
	logic [STAT_W-1:0] st_q;
	logic              sv_q;
	logic [TIME_W-1:0] ta_q;
	logic [TIME_W-1:0] rs_q;
	logic [LEN_W-1:0]  flen_q;

	// result register
	logic              o_run_valid_q;
	logic [JOB_W-1:0]  o_run_job_q;
	logic [STAT_W-1:0] o_status_q;
	logic              o_sv_q;
	logic [TIME_W-1:0] o_ta_q;
	logic [TIME_W-1:0] o_wt_q;
	logic [TIME_W-1:0] o_rs_q;

	logic [IDX_W-1:0]  scan_idx;
	logic [LEN_W-1:0]  scan_key;
	logic [LEN_W-1:0]  scan_val;
	logic [IDX_W-1:0]  last_idx;
	logic [TIME_W-1:0] elapsed;
	logic [TIME_W-1:0] rem0_ext;
	logic [TIME_W-1:0] flen_ext;
	logic              next_hr;
	logic [IDX_W-1:0]  new_head_src;

	assign scan_idx = pos_q[IDX_W-1:0];
	assign last_idx = IDX_W'(occ_q - CNT_W'(1));
	assign elapsed  = ev_time_q - hrs_q;
	assign rem0_ext = TIME_W'(rem_q[0]);
	assign flen_ext = TIME_W'(flen_q);

	// select the sort key for the running policy
	always_comb begin
		case (pol_q)
			POL_SJF: begin
				scan_key = len_q[scan_idx];
				scan_val = ev_len_q;
			end
			POL_PSJF: begin
				scan_key = rem_q[scan_idx];
				scan_val = ev_len_q;
			end
			default: begin
				scan_key = LEN_W'(prio_q[scan_idx]);
				scan_val = LEN_W'(ev_pri_q);
			end
		endcase
	end

	// entry that becomes head after a finish or a rotation
	always_comb begin
		if (cmd == CMD_FINISH) begin
			new_head_src = IDX_W'(1);
		end else begin
			new_head_src = (occ_q > CNT_W'(1)) ? IDX_W'(1) : IDX_W'(0);
		end
		next_hr = hr_q[new_head_src];
	end

	always_comb begin
		dp_st.mode      = ev_mode_q;
		dp_st.pol       = pol_q;
		dp_st.empty     = (occ_q == '0);
		dp_st.full      = (occ_q >= CNT_W'(DEPTH));
		dp_st.scan_done = (pos_q >= occ_q) || (scan_key > scan_val);
	end

	// queue payload, no reset
	always_ff @(posedge clk) begin
		case (cmd)
			CMD_PSJF: begin
				rem_q[0] <= (elapsed >= rem0_ext) ? '0 : LEN_W'(rem0_ext - elapsed);
			end
			CMD_INSERT: begin
				for (int i = 1; i < DEPTH; i++) begin
					if (CNT_W'(i) > pos_q && CNT_W'(i) <= occ_q) begin
						job_q[i]  <= job_q[i-1];
						arr_q[i]  <= arr_q[i-1];
						len_q[i]  <= len_q[i-1];
						rem_q[i]  <= rem_q[i-1];
						prio_q[i] <= prio_q[i-1];
						fr_q[i]   <= fr_q[i-1];
					end
				end
				job_q[scan_idx]  <= ev_job_q;
				arr_q[scan_idx]  <= ev_time_q;
				len_q[scan_idx]  <= ev_len_q;
				rem_q[scan_idx]  <= ev_len_q;
				prio_q[scan_idx] <= ev_pri_q;
				fr_q[scan_idx]   <= (pos_q == '0) ? ev_time_q : '0;
			end
			CMD_FINISH: begin
				for (int i = 0; i < DEPTH - 1; i++) begin
					job_q[i]  <= job_q[i+1];
					arr_q[i]  <= arr_q[i+1];
					len_q[i]  <= len_q[i+1];
					rem_q[i]  <= rem_q[i+1];
					prio_q[i] <= prio_q[i+1];
					fr_q[i]   <= fr_q[i+1];
				end
				if (!next_hr) begin
					fr_q[0] <= ev_time_q;
				end
			end
			CMD_ROTATE: begin
				for (int i = 0; i < DEPTH - 1; i++) begin
					if (IDX_W'(i) < last_idx) begin
						job_q[i]  <= job_q[i+1];
						arr_q[i]  <= arr_q[i+1];
						len_q[i]  <= len_q[i+1];
						rem_q[i]  <= rem_q[i+1];
						prio_q[i] <= prio_q[i+1];
						fr_q[i]   <= fr_q[i+1];
					end
				end
				job_q[last_idx]  <= job_q[0];
				arr_q[last_idx]  <= arr_q[0];
				len_q[last_idx]  <= len_q[0];
				rem_q[last_idx]  <= rem_q[0];
				prio_q[last_idx] <= prio_q[0];
				fr_q[last_idx]   <= fr_q[0];
				if (!next_hr) begin
					fr_q[0] <= ev_time_q;
				end
			end
			default: begin
			end
		endcase
	end

	// queue control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hr_q  <= '0;
			occ_q <= '0;
			hrs_q <= '0;
			pol_q <= POL_FCFS;
		end else begin
			if (cfg_wr_en) begin
				pol_q <= cfg_wr_data;
			end
			case (cmd)
				CMD_PSJF: begin
					hrs_q <= ev_time_q;
				end
				CMD_INSERT: begin
					for (int i = 1; i < DEPTH; i++) begin
						if (CNT_W'(i) > pos_q && CNT_W'(i) <= occ_q) begin
							hr_q[i] <= hr_q[i-1];
						end
					end
					hr_q[scan_idx] <= (pos_q == '0);
					occ_q          <= occ_q + CNT_W'(1);
					if (pos_q == '0) begin
						hrs_q <= ev_time_q;
					end
				end
				CMD_FINISH: begin
					for (int i = 0; i < DEPTH - 1; i++) begin
						hr_q[i] <= hr_q[i+1];
					end
					hr_q[0] <= 1'b1;
					occ_q   <= occ_q - CNT_W'(1);
					if (occ_q > CNT_W'(1)) begin
						hrs_q <= ev_time_q;
					end else begin
						hr_q[0] <= hr_q[1];
					end
				end
				CMD_ROTATE: begin
					for (int i = 0; i < DEPTH - 1; i++) begin
						if (IDX_W'(i) < last_idx) begin
							hr_q[i] <= hr_q[i+1];
						end
					end
					hr_q[last_idx] <= hr_q[0];
					hr_q[0]        <= 1'b1;
					hrs_q          <= ev_time_q;
				end
				default: begin
				end
			endcase
		end
	end

	// event latch, scan pointer and finish figures
	always_ff @(posedge clk) begin
		case (cmd)
			CMD_LOAD: begin
				ev_mode_q <= mode;
				ev_time_q <= event_time;
				ev_job_q  <= job_id;
				ev_len_q  <= run_length;
				ev_pri_q  <= job_priority;
				st_q      <= ST_OK;
				sv_q      <= 1'b0;
				ta_q      <= '0;
				rs_q      <= '0;
				flen_q    <= '0;
			end
			CMD_DROP:   st_q <= ST_FULL;
			CMD_EMPTY:  st_q <= ST_EMPTY;
			CMD_IGNORE: st_q <= ST_IGNORED;
			CMD_SCAN0, CMD_PSJF: pos_q <= '0;
			CMD_SCAN1:  pos_q <= CNT_W'(1);
			CMD_APPEND: pos_q <= occ_q;
			CMD_STEP:   pos_q <= pos_q + CNT_W'(1);
			CMD_FINISH: begin
				sv_q   <= 1'b1;
				ta_q   <= ev_time_q - arr_q[0];
				rs_q   <= fr_q[0] - arr_q[0];
				flen_q <= len_q[0];
			end
			default: begin
			end
		endcase
	end

	// capture the result and hold it until taken
	always_ff @(posedge clk) begin
		if (cmd == CMD_RESULT) begin
			o_run_valid_q <= (occ_q != '0);
			o_run_job_q   <= (occ_q != '0) ? job_q[0] : '0;
			o_status_q    <= st_q;
			o_sv_q        <= sv_q;
			o_ta_q        <= ta_q;
			o_wt_q        <= (ta_q >= flen_ext) ? ta_q - flen_ext : '0;
			o_rs_q        <= rs_q;
		end
	end

	assign run_valid   = o_run_valid_q;
	assign run_job     = o_run_job_q;
	assign status      = o_status_q;
	assign stats_valid = o_sv_q;
	assign turnaround  = o_ta_q;
	assign waiting     = o_wt_q;
	assign response    = o_rs_q;

endmodule

/* rtl/multi_policy_job_scheduler.sv */
// Sequence: an event is latched and decoded; a finish, expiry or drop then goes
//   to the result register, an append through the insert step, and an ordered
//   insertion scans the queue entries before the insert. One event at a time,
//   held off by output stall; the insertion scan over the queue entries sets the worst case.
// Reset: arst_n clears the queue count, first-run marks, run start and
//   policy (FCFS); queue payload holds no reset value.
// ----------------------------------------------------------------------------
// multi_policy_job_scheduler
// Ordered job queue whose head is the running job, with FCFS, SJF, PSJF,
// priority, preemptive priority and round-robin placement.
// ----------------------------------------------------------------------------
module multi_policy_job_scheduler (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [msch_pkg::POL_W-1:0]    cfg_wr_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [msch_pkg::MODE_W-1:0]   mode,
	input  logic [msch_pkg::TIME_W-1:0]   event_time,
	input  logic [msch_pkg::JOB_W-1:0]    job_id,
	input  logic [msch_pkg::LEN_W-1:0]    run_length,
	input  logic [msch_pkg::PRI_W-1:0]    job_priority,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          run_valid,
	output logic [msch_pkg::JOB_W-1:0]    run_job,
	output logic [msch_pkg::STAT_W-1:0]   status,
	output logic                          stats_valid,
	output logic [msch_pkg::TIME_W-1:0]   turnaround,
	output logic [msch_pkg::TIME_W-1:0]   waiting,
	output logic [msch_pkg::TIME_W-1:0]   response
);
	import msch_pkg::*;

	cmd_t       cmd;
	dp_status_t dp_st;

	msch_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.dp_st     (dp_st),
		.cmd       (cmd)
	);

	msch_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.cmd          (cmd),
		.dp_st        (dp_st),
		.mode         (mode),
		.event_time   (event_time),
		.job_id       (job_id),
		.run_length   (run_length),
		.job_priority (job_priority),
		.run_valid    (run_valid),
		.run_job      (run_job),
		.status       (status),
		.stats_valid  (stats_valid),
		.turnaround   (turnaround),
		.waiting      (waiting),
		.response     (response)
	);

`ifndef ASSERT_OFF
	// no new item while a result waits
	a_hold_input: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("item accepted while a result is pending");

	// an empty queue reports no job
	a_idle_job: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !run_valid |-> run_job == '0)
		else $error("job reported with an empty queue");

	// time figures only with a finish
	a_stats_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !stats_valid |-> turnaround == '0 && waiting == '0 && response == '0)
		else $error("time figures without a finish");

	// a dropped arrival implies a full, running queue
	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_FULL |-> run_valid && !stats_valid)
		else $error("drop reported with a non-full queue");
`endif

endmodule

/* tb/sv/multi_policy_job_scheduler_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// multi_policy_job_scheduler_test
// Self-checking bench for the job scheduler: directed events under FCFS,
// round-robin and preemptive priority, then random event streams under each
// policy, each result checked against a behavioural queue.
module multi_policy_job_scheduler_test;
	import msch_pkg::*;

	typedef struct {
		logic [JOB_W-1:0]  job;
		logic [TIME_W-1:0] arrival;
		logic [LEN_W-1:0]  length;
		logic [LEN_W-1:0]  remaining;
		logic [PRI_W-1:0]  prio;
		logic [TIME_W-1:0] first_run;
		logic              has_run;
	} job_entry_t;

	typedef struct packed {
		logic              run_valid;
		logic [JOB_W-1:0]  run_job;
		logic [STAT_W-1:0] status;
		logic              stats_valid;
		logic [TIME_W-1:0] turnaround;
		logic [TIME_W-1:0] waiting;
		logic [TIME_W-1:0] response;
	} sched_result_t;

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic [POL_W-1:0] cfg_wr_data;
	logic in_valid;
	logic in_stall;
	logic [MODE_W-1:0] mode;
	logic [TIME_W-1:0] event_time;
	logic [JOB_W-1:0] job_id;
	logic [LEN_W-1:0] run_length;
	logic [PRI_W-1:0] job_priority;
	logic out_valid;
	logic out_stall;
	logic run_valid;
	logic [JOB_W-1:0] run_job;
	logic [STAT_W-1:0] status;
	logic stats_valid;
	logic [TIME_W-1:0] turnaround;
	logic [TIME_W-1:0] waiting;
	logic [TIME_W-1:0] response;

	// predictor state
	job_entry_t job_queue[DEPTH];
	int unsigned queue_count;
	logic [TIME_W-1:0] run_start;
	logic [POL_W-1:0] policy;
	logic [TIME_W-1:0] clock_ticks;

	sched_result_t pending_results[$];
	int unsigned mismatches;
	int unsigned stall_cycles;
	longint unsigned cycle_count;

	multi_policy_job_scheduler u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.mode(mode), .event_time(event_time), .job_id(job_id),
		.run_length(run_length), .job_priority(job_priority),
		.out_valid(out_valid), .out_stall(out_stall),
		.run_valid(run_valid), .run_job(run_job), .status(status),
		.stats_valid(stats_valid), .turnaround(turnaround),
		.waiting(waiting), .response(response)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// mark the head as started at time t
	function automatic void start_head(logic [TIME_W-1:0] t);
		run_start = t;
		if (!job_queue[0].has_run) begin
			job_queue[0].first_run = t;
			job_queue[0].has_run = 1'b1;
		end
	endfunction

	// first position from 'from' whose key is strictly greater than v
	function automatic int unsigned slot_after(int unsigned from, bit by_prio,
			bit by_rem, logic [LEN_W-1:0] v);
		int unsigned p;
		logic [LEN_W-1:0] k;
		p = from;
		while (p < queue_count) begin
			k = by_prio ? LEN_W'(job_queue[p].prio)
				: (by_rem ? job_queue[p].remaining : job_queue[p].length);
			if (k > v)
				break;
			p++;
		end
		return p;
	endfunction

	function automatic sched_result_t schedule_event(logic [MODE_W-1:0] m,
			logic [TIME_W-1:0] t, logic [JOB_W-1:0] id, logic [LEN_W-1:0] len,
			logic [PRI_W-1:0] pri);
		sched_result_t r;
		job_entry_t tmp;
		int unsigned pos;
		logic [TIME_W-1:0] el;
		r = '0;
		if (m == MODE_ARRIVE) begin
			if (queue_count >= DEPTH) begin
				r.status = ST_FULL;
			end else begin
				if (queue_count == 0)
					pos = 0;
				else if (policy == POL_SJF)
					pos = slot_after(1, 0, 0, len);
				else if (policy == POL_PRI)
					pos = slot_after(1, 1, 0, LEN_W'(pri));
				else if (policy == POL_PSJF) begin
					el = t - run_start;
					job_queue[0].remaining = (el >= TIME_W'(job_queue[0].remaining)) ? '0
						: job_queue[0].remaining - LEN_W'(el);
					run_start = t;
					pos = slot_after(0, 0, 1, len);
				end else if (policy == POL_PPRI)
					pos = slot_after(0, 1, 0, LEN_W'(pri));
				else
					pos = queue_count;
				for (int unsigned i = queue_count; i > pos; i--)
					job_queue[i] = job_queue[i-1];
				job_queue[pos] = '{id, t, len, len, pri, '0, 1'b0};
				queue_count++;
				if (pos == 0)
					start_head(t);
			end
		end else if (m == MODE_FINISH) begin
			if (queue_count == 0) begin
				r.status = ST_EMPTY;
			end else begin
				r.stats_valid = 1'b1;
				r.turnaround = t - job_queue[0].arrival;
				r.waiting = (r.turnaround >= TIME_W'(job_queue[0].length))
					? r.turnaround - TIME_W'(job_queue[0].length) : '0;
				r.response = job_queue[0].first_run - job_queue[0].arrival;
				for (int unsigned i = 1; i < queue_count; i++)
					job_queue[i-1] = job_queue[i];
				queue_count--;
				if (queue_count > 0)
					start_head(t);
			end
		end else if (m == MODE_EXPIRE) begin
			if (policy != POL_RR)
				r.status = ST_IGNORED;
			else if (queue_count == 0)
				r.status = ST_EMPTY;
			else begin
				// rotate the head to the tail
				tmp = job_queue[0];
				for (int unsigned i = 1; i < queue_count; i++)
					job_queue[i-1] = job_queue[i];
				job_queue[queue_count-1] = tmp;
				start_head(t);
			end
		end
		r.run_valid = queue_count > 0;
		r.run_job = (queue_count > 0) ? job_queue[0].job : '0;
		return r;
	endfunction

	// valid stays high into the next item when there is no gap
	task automatic send_event(logic [MODE_W-1:0] m, logic [TIME_W-1:0] t,
			logic [JOB_W-1:0] id, logic [LEN_W-1:0] len, logic [PRI_W-1:0] pri);
		int unsigned gap;
		gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= m;
		event_time <= t;
		job_id <= id;
		run_length <= len;
		job_priority <= pri;
		pending_results.push_back(schedule_event(m, t, id, len, pri));
		do @(posedge clk); while (in_stall);
	endtask

	// advance time and send one random event with a realistic mix
	task automatic send_random(int unsigned arrive_pct);
		logic [MODE_W-1:0] m;
		logic [LEN_W-1:0] len;
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < arrive_pct)
			m = MODE_ARRIVE;
		else if (r < 95)
			m = ($urandom_range(0, 1) == 0) ? MODE_FINISH : MODE_EXPIRE;
		else
			m = 2'd3;
		clock_ticks += ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(0, 40);
		len = ($urandom_range(0, 3) == 0) ? LEN_W'($urandom()) : LEN_W'($urandom_range(1, 20));
		if (len == 0)
			len = 1;
		send_event(m, clock_ticks, JOB_W'($urandom()), len,
			($urandom_range(0, 1) == 0) ? PRI_W'($urandom()) : PRI_W'($urandom_range(0, 4)));
	endtask

	// wait for the block to drain, then change policy
	task automatic set_policy(logic [POL_W-1:0] p);
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= p;
		policy = p;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic test_directed_edges();
		set_policy(POL_FCFS);
		send_event(MODE_FINISH, 32'd5, 16'hFFFF, 24'd1, 8'd0);
		send_event(MODE_EXPIRE, 32'd6, '0, 24'd1, 8'd0);
		send_event(MODE_ARRIVE, 32'hFFFF_FFF0, 16'hFFFF, 24'hFF_FFFF, 8'hFF);
		send_event(MODE_ARRIVE, 32'hFFFF_FFFF, 16'h0000, 24'd1, 8'h00);
		send_event(2'd3, 32'd0, '0, 24'd1, 8'd0);
		send_event(MODE_FINISH, 32'd20, '0, 24'd1, 8'd0);
		send_event(MODE_FINISH, 32'd21, '0, 24'd1, 8'd0);
		set_policy(POL_RR);
		send_event(MODE_EXPIRE, 32'd30, '0, 24'd1, 8'd0);
		send_event(MODE_ARRIVE, 32'd31, 16'd7, 24'd3, 8'd1);
		send_event(MODE_EXPIRE, 32'd32, '0, 24'd1, 8'd0);
		send_event(MODE_ARRIVE, 32'd33, 16'd8, 24'd3, 8'd1);
		send_event(MODE_EXPIRE, 32'd34, '0, 24'd1, 8'd0);
		send_event(MODE_FINISH, 32'd40, '0, 24'd1, 8'd0);
		send_event(MODE_FINISH, 32'd41, '0, 24'd1, 8'd0);
	endtask

	// fill past depth under a preemptive policy to hit the drop case
	task automatic test_full_queue();
		set_policy(POL_PPRI);
		for (int i = 0; i < DEPTH + 2; i++)
			send_event(MODE_ARRIVE, 32'(100 + i), JOB_W'(i), 24'd5, PRI_W'(9 - (i % 5)));
		// hold off until everything has drained back
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		for (int i = 0; i < DEPTH; i++)
			send_event(MODE_FINISH, 32'(200 + i), '0, 24'd1, 8'd0);
	endtask

	task automatic test_random_policies();
		logic [POL_W-1:0] p;
		for (int phase = 0; phase < 16; phase++) begin
			p = (phase < 8) ? POL_W'(phase) : POL_W'($urandom_range(0, 7));
			set_policy(p);
			for (int i = 0; i < 95; i++)
				send_random((i % 40 < 25) ? 60 : 35);
		end
	endtask

	// check each result against the oldest expectation
	always @(posedge clk) begin
		sched_result_t got;
		sched_result_t exp_r;
		if (arst_n && out_valid && !out_stall) begin
			got = '{run_valid, run_job, status, stats_valid, turnaround, waiting, response};
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %p", got);
			end else begin
				exp_r = pending_results.pop_front();
				if (got !== exp_r) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %p actual %p", exp_r, got);
				end
			end
		end
	end

	// receiver stalls, drawn per result
	always @(posedge clk) begin
		if (stall_cycles != 0) begin
			stall_cycles <= stall_cycles - 1;
			out_stall <= 1'b1;
		end else if (out_valid && !out_stall) begin
			stall_cycles <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
			out_stall <= 1'b0;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 400000) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		in_valid = 1'b0;
		mode = '0;
		event_time = '0;
		job_id = '0;
		run_length = 24'd1;
		job_priority = '0;
		out_stall = 1'b0;
		stall_cycles = 0;
		cycle_count = 0;
		mismatches = 0;
		queue_count = 0;
		run_start = '0;
		policy = POL_FCFS;
		clock_ticks = '0;
		for (int i = 0; i < DEPTH; i++)
			job_queue[i] = '{'0, '0, '0, '0, '0, '0, 1'b0};
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_edges();
		test_full_queue();
		test_random_policies();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
